### src/subarray_palindrome_query_unit_defines.svh
`ifndef SUBARRAY_PALINDROME_QUERY_UNIT_DEFINES_SVH
`define SUBARRAY_PALINDROME_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	localparam int IDX_W   = 12;
	localparam int VAL_W   = 32;
	localparam int LEN_W   = 12;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [PADDR_W-1:0] ADDR_ARRAY_LENGTH = '0;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_CHECK,
		CMD_ANSWER
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PUT
	} back_state_t;

endpackage

### src/spq_in_if.sv
`timescale 1ns / 1ps

interface spq_in_if;
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic [spq_pkg::IDX_W-1:0] load_index;
	logic [spq_pkg::VAL_W-1:0] load_value;
	logic [spq_pkg::IDX_W-1:0] query_start;
	logic [spq_pkg::IDX_W-1:0] query_end;

	modport source (
		output valid, mode, load_index, load_value, query_start, query_end,
		input  ready
	);
	modport sink (
		input  valid, mode, load_index, load_value, query_start, query_end,
		output ready
	);
endinterface

### src/spq_out_if.sv
`timescale 1ns / 1ps

interface spq_out_if;
	logic valid;
	logic ready;
	logic is_palindrome;

	modport source (
		output valid, is_palindrome,
		input  ready
	);
	modport sink (
		input  valid, is_palindrome,
		output ready
	);
endinterface

### src/spq_front.sv
`timescale 1ns / 1ps

module spq_front #(
	parameter int MAX_LEN    = 2048,
	parameter int VALUE_BITS = 32,
	parameter int AW         = $clog2(MAX_LEN),
	parameter int ENTRY_W    = 2 + 2 * AW + VALUE_BITS + 1
) (
	spq_in_if.sink                   cmd,
	input  logic [spq_pkg::LEN_W-1:0] array_length,
	output logic                     push_valid,
	input  logic                     push_ready,
	output logic [ENTRY_W-1:0]       push_data
);

	localparam int CLOG_LEN = $clog2(MAX_LEN + 1);
	localparam int CW = (spq_pkg::IDX_W > CLOG_LEN) ? spq_pkg::IDX_W : CLOG_LEN;
	localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LEN);

	typedef struct packed {
		spq_pkg::cmd_kind_t    kind;
		logic [AW-1:0]         lo;
		logic [AW-1:0]         hi;
		logic [VALUE_BITS-1:0] value;
		logic                  answer;
	} entry_t;

	entry_t        entry;
	logic [CW-1:0] eff_len;
	logic [CW-1:0] idx_w;
	logic [CW-1:0] start_w;
	logic [CW-1:0] end_w;
	logic          load_ok;
	logic          query_ok;

	always_comb begin
		idx_w   = CW'(cmd.load_index);
		start_w = CW'(cmd.query_start);
		end_w   = CW'(cmd.query_end);
		eff_len = (CW'(array_length) > MAX_LEN_C) ? MAX_LEN_C : CW'(array_length);

		load_ok  = (idx_w != '0) && (idx_w <= MAX_LEN_C);
		query_ok = (start_w != '0) && (start_w <= end_w) && (end_w <= eff_len);

		entry.value  = VALUE_BITS'(cmd.load_value);
		entry.answer = 1'b0;
		if (cmd.mode == spq_pkg::MODE_LOAD) begin
			entry.kind = spq_pkg::CMD_LOAD;
			entry.lo   = AW'(idx_w - CW'(1));
			entry.hi   = AW'(idx_w - CW'(1));
		end else begin
			entry.lo = AW'(start_w - CW'(1));
			entry.hi = AW'(end_w - CW'(1));
			if (!query_ok) begin
				entry.kind = spq_pkg::CMD_ANSWER;
			end else if (start_w == end_w) begin
				// A single element always reads the same both ways.
				entry.kind   = spq_pkg::CMD_ANSWER;
				entry.answer = 1'b1;
			end else begin
				entry.kind = spq_pkg::CMD_CHECK;
			end
		end
	end

	// Loads outside the store are taken and dropped.
	assign push_valid = cmd.valid && !((cmd.mode == spq_pkg::MODE_LOAD) && !load_ok);
	assign push_data  = entry;
	assign cmd.ready  = push_ready;

endmodule

### src/spq_queue.sv
`timescale 1ns / 1ps

module spq_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]            entries_q [spq_pkg::Q_DEPTH];
	logic [spq_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [spq_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [spq_pkg::Q_CNT_W-1:0] count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = (count_q != spq_pkg::Q_CNT_W'(spq_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/spq_back.sv
`timescale 1ns / 1ps
`include "subarray_palindrome_query_unit_defines.svh"

module spq_back #(
	parameter int MAX_LEN    = 2048,
	parameter int VALUE_BITS = 32,
	parameter int AW         = $clog2(MAX_LEN),
	parameter int ENTRY_W    = 2 + 2 * AW + VALUE_BITS + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [ENTRY_W-1:0] pop_data,
	spq_out_if.source          rsp
);

	typedef struct packed {
		spq_pkg::cmd_kind_t    kind;
		logic [AW-1:0]         lo;
		logic [AW-1:0]         hi;
		logic [VALUE_BITS-1:0] value;
		logic                  answer;
	} entry_t;

	entry_t                entry;
	spq_pkg::back_state_t  state_q;
	spq_pkg::back_state_t  state_d;
	logic [VALUE_BITS-1:0] mem [MAX_LEN];
	logic [VALUE_BITS-1:0] rd_a_q;
	logic [VALUE_BITS-1:0] rd_b_q;
	logic [AW-1:0]         lo_q;
	logic [AW-1:0]         hi_q;
	logic                  rd_vld_q;
	logic                  res_q;
	logic                  rsp_valid_q;
	logic                  rsp_data_q;
	logic                  issue;
	logic                  mismatch;
	logic                  mem_we;
	logic                  ld_ptrs;
	logic                  step;
	logic                  res_we;
	logic                  res_d;
	logic                  out_load;

	assign entry    = entry_t'(pop_data);
	assign issue    = (lo_q < hi_q);
	assign mismatch = rd_vld_q && (rd_a_q != rd_b_q);

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		mem_we    = 1'b0;
		ld_ptrs   = 1'b0;
		step      = 1'b0;
		res_we    = 1'b0;
		res_d     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					unique case (entry.kind)
						spq_pkg::CMD_LOAD: begin
							mem_we = 1'b1;
						end
						spq_pkg::CMD_CHECK: begin
							ld_ptrs = 1'b1;
							state_d = spq_pkg::ST_RUN;
						end
						spq_pkg::CMD_ANSWER: begin
							res_we  = 1'b1;
							res_d   = entry.answer;
							state_d = spq_pkg::ST_PUT;
						end
						default: begin
						end
					endcase
				end
			end
			spq_pkg::ST_RUN: begin
				step = issue;
				if (mismatch) begin
					res_we  = 1'b1;
					res_d   = 1'b0;
					state_d = spq_pkg::ST_PUT;
				end else if (!issue && !rd_vld_q) begin
					res_we  = 1'b1;
					res_d   = 1'b1;
					state_d = spq_pkg::ST_PUT;
				end
			end
			spq_pkg::ST_PUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = spq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::ST_IDLE;
			rd_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= (state_d == spq_pkg::ST_RUN) && step;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ptrs) begin
			lo_q <= entry.lo;
			hi_q <= entry.hi;
		end else if (step) begin
			lo_q <= lo_q + 1'b1;
			hi_q <= hi_q - 1'b1;
		end
		if (res_we) begin
			res_q <= res_d;
		end
		if (out_load) begin
			rsp_data_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[entry.lo] <= entry.value;
		end
		rd_a_q <= mem[lo_q];
		rd_b_q <= mem[hi_q];
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.is_palindrome = rsp_data_q;

	`SPQ_ASSERT_NOW(a_pop_only_idle, pop_valid && pop_ready, state_q == spq_pkg::ST_IDLE, "item taken from the queue outside idle")
	`SPQ_ASSERT_NOW(a_read_only_run, rd_vld_q, state_q == spq_pkg::ST_RUN, "pair compare pending outside a scan")
	`SPQ_ASSERT_NEXT(a_check_starts_scan, (state_q == spq_pkg::ST_IDLE) && pop_valid && (entry.kind == spq_pkg::CMD_CHECK), state_q == spq_pkg::ST_RUN, "range check did not start a scan")
	`SPQ_ASSERT_NEXT(a_put_fills_output, out_load, rsp_valid_q, "finished result did not reach the output register")

endmodule

### src/subarray_palindrome_query_unit.sv
`timescale 1ns / 1ps

// Channel   Dir   Payload                                          Moves when
// cmd       in    mode, load_index, load_value, query_start/end    valid && ready
// rsp       out   is_palindrome                                    valid && ready
// apb       in    array_length at byte address 0                   psel, penable, pwrite
//
// An accepted load passes through the queue to the element store write.
// A query's pair scan reads one pair per cycle from the dual-read element store.
// Rejected and single-element queries finish without a pair scan.
// A two-entry queue lets cmd keep accepting items while a scan runs or rsp stalls.
// arst_n clears control state and array_length; the element store is not cleared.

module subarray_palindrome_query_unit #(
	parameter int MAX_LEN    = 2048,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	spq_in_if.sink                       cmd,
	spq_out_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spq_pkg::PADDR_W-1:0]  paddr,
	input  logic [spq_pkg::PDATA_W-1:0]  pwdata,
	output logic [spq_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int AW      = $clog2(MAX_LEN);
	localparam int ENTRY_W = 2 + 2 * AW + VALUE_BITS + 1;

	logic [spq_pkg::LEN_W-1:0] len_q;
	logic                      reg_hit;
	logic                      push_valid;
	logic                      push_ready;
	logic [ENTRY_W-1:0]        push_data;
	logic                      pop_valid;
	logic                      pop_ready;
	logic [ENTRY_W-1:0]        pop_data;

	assign pready  = 1'b1;
	assign reg_hit = (paddr == spq_pkg::ADDR_ARRAY_LENGTH);
	assign prdata  = reg_hit ? spq_pkg::PDATA_W'(len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			len_q <= pwdata[spq_pkg::LEN_W-1:0];
		end
	end

	spq_front #(
		.MAX_LEN   (MAX_LEN),
		.VALUE_BITS(VALUE_BITS),
		.AW        (AW),
		.ENTRY_W   (ENTRY_W)
	) u_front (
		.cmd         (cmd),
		.array_length(len_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	spq_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	spq_back #(
		.MAX_LEN   (MAX_LEN),
		.VALUE_BITS(VALUE_BITS),
		.AW        (AW),
		.ENTRY_W   (ENTRY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.rsp      (rsp)
	);

endmodule

### verif/palindrome_checker.sv
`timescale 1ns / 1ps

module palindrome_checker
	import spq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	spq_in_if                  cmd,
	spq_out_if                 rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int unsigned        mismatches,
	output int unsigned        outstanding
);

	localparam int MAX_LEN = 2048;

	logic [VAL_W-1:0] element_copy [1:MAX_LEN];
	logic [LEN_W-1:0] length_copy;
	logic             answer_q [$];
	logic             expected_bit;

	function automatic logic palindrome_answer(input logic [IDX_W-1:0] first,
			input logic [IDX_W-1:0] last);
		int lo;
		int hi;
		int limit;
		limit = (length_copy > MAX_LEN) ? MAX_LEN : int'(length_copy);
		if (first < 1 || first > last || last > limit)
			return 1'b0;
		lo = first;
		hi = last;
		while (lo < hi) begin
			if (element_copy[lo] != element_copy[hi])
				return 1'b0;
			lo++;
			hi--;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_q.delete();
			length_copy = '0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					$error("is_palindrome: no item expected, got %0d", rsp.is_palindrome);
					mismatches <= mismatches + 1;
				end else begin
					expected_bit = answer_q.pop_front();
					if (rsp.is_palindrome !== expected_bit) begin
						$error("is_palindrome: expected %0d, got %0d", expected_bit,
							rsp.is_palindrome);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.mode == MODE_LOAD) begin
					if (cmd.load_index >= 1 && cmd.load_index <= MAX_LEN)
						element_copy[cmd.load_index] = cmd.load_value;
				end else begin
					answer_q.push_back(palindrome_answer(cmd.query_start, cmd.query_end));
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_ARRAY_LENGTH)
				length_copy = pwdata[LEN_W-1:0];
			outstanding <= answer_q.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import spq_pkg::*;

	localparam int MAX_LEN     = 2048;
	localparam int STALL_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int unsigned        mismatches;
	int unsigned        outstanding;
	int unsigned        idle_cycles = 0;
	int unsigned        items_sent = 0;
	int                 src_idle_pct;
	int                 sink_stall_pct;
	int                 cur_len;
	bit                 loaded [1:MAX_LEN];
	logic [VAL_W-1:0]   window_vals [0:MAX_LEN-1];

	spq_in_if  cmd_if ();
	spq_out_if rsp_if ();

	subarray_palindrome_query_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	palindrome_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_if),
		.rsp         (rsp_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic int eff_len();
		return (cur_len > MAX_LEN) ? MAX_LEN : cur_len;
	endfunction

	function automatic bit span_loaded(input int first, input int last);
		for (int i = first; i <= last; i++) begin
			if (!loaded[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] qs,
			input logic [IDX_W-1:0] qe);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid       <= 1'b1;
		cmd_if.mode        <= mode;
		cmd_if.load_index  <= idx;
		cmd_if.load_value  <= val;
		cmd_if.query_start <= qs;
		cmd_if.query_end   <= qe;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
	endtask

	task automatic send_load(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		send_item(MODE_LOAD, idx, val, IDX_W'($urandom), IDX_W'($urandom));
		if (idx >= 1 && idx <= MAX_LEN) begin
			loaded[idx] = 1'b1;
			items_sent++;
		end
	endtask

	// A query that would read an element never loaded is sent with start 0, which the unit rejects.
	task automatic send_query(input logic [IDX_W-1:0] qs, input logic [IDX_W-1:0] qe);
		logic [IDX_W-1:0] first;
		first = qs;
		if (qs >= 1 && qs <= qe && qe <= eff_len() && !span_loaded(qs, qe))
			first = '0;
		send_item(MODE_QUERY, IDX_W'($urandom), VAL_W'($urandom), first, qe);
		items_sent++;
	endtask

	task automatic settle();
		cmd_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] len);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ARRAY_LENGTH;
		pwdata  <= {(PDATA_W-LEN_W)'($urandom), len};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_len = len;
	endtask

	task automatic palindrome_burst(input int w);
		int s;
		int e;
		int k;
		int a;
		int b;
		int n;
		bit tiny;
		s = $urandom_range(eff_len() - w + 1, 1);
		case ($urandom_range(3))
			0: s = 1;
			1: s = eff_len() - w + 1;
			default: ;
		endcase
		e = s + w - 1;
		tiny = $urandom_range(1);
		for (int i = 0; i < w; i++)
			window_vals[i] = tiny ? VAL_W'($urandom_range(2)) : VAL_W'($urandom);
		for (int i = 0; i < w / 2; i++)
			window_vals[w-1-i] = window_vals[i];
		if ($urandom_range(2) == 0)
			window_vals[$urandom_range(w - 1)] ^= VAL_W'(1) << $urandom_range(VAL_W - 1);
		for (int i = 0; i < w; i++)
			send_load(IDX_W'(s + i), window_vals[i]);
		n = $urandom_range(4, 1);
		for (int j = 0; j < n; j++) begin
			case ($urandom_range(3))
				0: send_query(IDX_W'(s), IDX_W'(e));
				1: begin
					k = $urandom_range((w - 1) / 2);
					send_query(IDX_W'(s + k), IDX_W'(e - k));
				end
				2: begin
					a = $urandom_range(e, s);
					b = $urandom_range(e, a);
					send_query(IDX_W'(a), IDX_W'(b));
				end
				default: begin
					if ($urandom_range(1))
						send_query(IDX_W'(e), IDX_W'(s - 1));
					else
						send_query(IDX_W'(s), IDX_W'(eff_len() + 1));
				end
			endcase
		end
	endtask

	task automatic noise_item();
		logic [IDX_W-1:0] qs;
		logic [IDX_W-1:0] qe;
		if ($urandom_range(1)) begin
			send_load(IDX_W'($urandom), VAL_W'($urandom));
		end else begin
			qs = $urandom_range(1) ? IDX_W'($urandom) : IDX_W'($urandom_range(eff_len() + 1));
			case ($urandom_range(2))
				0: qe = IDX_W'($urandom);
				1: qe = IDX_W'(eff_len());
				default: qe = IDX_W'(eff_len() + 1);
			endcase
			send_query(qs, qe);
		end
	endtask

	task automatic run_phase(input logic [LEN_W-1:0] len, input int src, input int sink,
			input int n, input int big);
		int stop_at;
		int cap;
		write_length(len);
		src_idle_pct   = src;
		sink_stall_pct = sink;
		stop_at = items_sent + n;
		if (big > 0)
			palindrome_burst(big);
		while (items_sent < stop_at) begin
			if (eff_len() > 0 && $urandom_range(99) < 80) begin
				cap = ($urandom_range(19) == 0) ? 64 : 16;
				if (cap > eff_len())
					cap = eff_len();
				palindrome_burst($urandom_range(cap, 1));
			end else begin
				noise_item();
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		cmd_if.valid       = 1'b0;
		cmd_if.mode        = MODE_LOAD;
		cmd_if.load_index  = '0;
		cmd_if.load_value  = '0;
		cmd_if.query_start = '0;
		cmd_if.query_end   = '0;
		rsp_if.ready       = 1'b0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		cur_len            = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_query(1, 1);
		send_query(0, 0);
		write_length(MAX_LEN);
		send_load(1, '0);
		send_load(2, '1);
		send_load(3, '1);
		send_load(4, '0);
		send_load(MAX_LEN - 1, 32'hA5A5_A5A5);
		send_load(MAX_LEN, 32'hA5A5_A5A5);
		send_load(0, 32'h1234_5678);
		send_load('1, 32'h8765_4321);
		send_query(1, 4);
		send_query(1, 3);
		send_query(2, 3);
		send_query(3, 3);
		send_query(MAX_LEN - 1, MAX_LEN);
		send_query(MAX_LEN, MAX_LEN);
		send_query(4, 3);
		send_query(0, 4);
		send_query(MAX_LEN, '1);
		send_query('1, '1);
		send_query(MAX_LEN + 1, MAX_LEN + 1);

		run_phase(32, 0, 0, 110, 0);
		run_phase('1, 55, 0, 90, 0);
		run_phase(1, 0, 55, 60, 0);
		run_phase(300, 7, 7, 110, 0);
		run_phase(0, 0, 55, 20, 0);
		run_phase(MAX_LEN, 0, 0, 170, 150);

		settle();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/spq_pkg.sv
src/spq_in_if.sv
src/spq_out_if.sv
src/spq_front.sv
src/spq_queue.sv
src/spq_back.sv
src/subarray_palindrome_query_unit.sv
verif/palindrome_checker.sv
verif/tb_top.sv
